// ----- sv/drpi_pkg.sv -----
// Shared types, constants and lookup functions for the dead-reckoning pose integrator.
package drpi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;
    localparam int CORDIC_W         = 34;
    localparam int TRIG_W           = 25;
    localparam int MUL_A_W          = 25;
    localparam int MUL_B_W          = 32;
    localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
    localparam int PROD_W           = 40;
    localparam int ACC_W            = 72;
    localparam int MATH_SLOTS       = 12;
    localparam int SLOT_W           = $clog2(MATH_SLOTS);

    localparam logic [29:0] TRIG_GAIN_Q30  = 30'd652032874;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    typedef struct packed {
        logic signed [23:0] linear_speed;
        logic signed [23:0] lateral_speed;
        logic signed [23:0] yaw_rate;
        logic        [15:0] time_step;
    } drpi_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic        [31:0] heading_out;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [23:0] speed_echo;
        logic signed [23:0] lateral_echo;
        logic signed [23:0] yaw_rate_echo;
    } drpi_out_t;

    // Operand pairs presented to the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_V_DT,
        MUL_W_DT,
        MUL_DHI_CQ,
        MUL_DLO_CQ,
        MUL_DHI_SQ,
        MUL_DLO_SQ,
        MUL_WHI_K,
        MUL_WLO_K
    } mul_op_t;

    // What is done with the product registered in the previous cycle.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_STORE_DIST,
        ACT_STORE_WD,
        ACT_ACC_HI_POS,
        ACT_ACC_HI_HEAD,
        ACT_ACC_LO,
        ACT_WRITE_X,
        ACT_WRITE_Y,
        ACT_WRITE_H
    } act_t;

    typedef struct packed {
        mul_op_t mul_op;
        act_t    act;
    } slot_cmd_t;

    typedef struct packed {
        logic      in_load;
        logic      rot_load;
        logic      rot_half;
        logic      rot_step;
        logic      trig_load;
        slot_cmd_t slot;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rot_last;
    } dp_status_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // Multiply schedule: a slot issues at most one product and may act on the one from the previous slot.
    function automatic slot_cmd_t slot_cmd(input logic [SLOT_W-1:0] slot);
        slot_cmd_t c;
        case (slot)
            4'd0:    c = '{mul_op: MUL_V_DT,   act: ACT_NONE};
            4'd1:    c = '{mul_op: MUL_W_DT,   act: ACT_STORE_DIST};
            4'd2:    c = '{mul_op: MUL_DHI_CQ, act: ACT_STORE_WD};
            4'd3:    c = '{mul_op: MUL_DLO_CQ, act: ACT_ACC_HI_POS};
            4'd4:    c = '{mul_op: MUL_NONE,   act: ACT_ACC_LO};
            4'd5:    c = '{mul_op: MUL_DHI_SQ, act: ACT_WRITE_X};
            4'd6:    c = '{mul_op: MUL_DLO_SQ, act: ACT_ACC_HI_POS};
            4'd7:    c = '{mul_op: MUL_NONE,   act: ACT_ACC_LO};
            4'd8:    c = '{mul_op: MUL_WHI_K,  act: ACT_WRITE_Y};
            4'd9:    c = '{mul_op: MUL_WLO_K,  act: ACT_ACC_HI_HEAD};
            4'd10:   c = '{mul_op: MUL_NONE,   act: ACT_ACC_LO};
            4'd11:   c = '{mul_op: MUL_NONE,   act: ACT_WRITE_H};
            default: c = '{mul_op: MUL_NONE,   act: ACT_NONE};
        endcase
        return c;
    endfunction

endpackage

// ----- sv/drpi_ctrl.sv -----
// Sequencing state machine for the pose integrator: handshakes, rotation passes and multiply slots.
module drpi_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_valid,
    output logic                   tick_stall,
    output logic                   pose_valid,
    input  logic                   pose_stall,
    input  drpi_pkg::dp_status_t   status,
    output drpi_pkg::ctrl_cmd_t    cmd
);
    import drpi_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ROT1  = 7'b0000010,
        ST_TRIG  = 7'b0000100,
        ST_MATH  = 7'b0001000,
        ST_LOAD2 = 7'b0010000,
        ST_ROT2  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MATH_SLOTS - 1);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        slot_next      = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    cmd.in_load  = 1'b1;
                    cmd.rot_load = 1'b1;
                    state_next   = ST_ROT1;
                end
            end
            ST_ROT1:
            begin
                cmd.rot_step = 1'b1;
                if (status.rot_last)
                begin
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG:
            begin
                cmd.trig_load = 1'b1;
                slot_next     = '0;
                state_next    = ST_MATH;
            end
            ST_MATH:
            begin
                cmd.slot  = slot_cmd(slot_reg);
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_LAST)
                begin
                    state_next = ST_LOAD2;
                end
            end
            ST_LOAD2:
            begin
                cmd.rot_load = 1'b1;
                cmd.rot_half = 1'b1;
                state_next   = ST_ROT2;
            end
            ST_ROT2:
            begin
                cmd.rot_step = 1'b1;
                if (status.rot_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !pose_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!pose_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign tick_stall = (state_reg != ST_IDLE);
    assign pose_valid = out_valid_reg;

endmodule

// ----- sv/drpi_dp.sv -----
// Datapath of the pose integrator: CORDIC rotator, shared multiplier, accumulator and pose state.
module drpi_dp #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  drpi_pkg::drpi_in_t     tick,
    input  drpi_pkg::ctrl_cmd_t    cmd,
    output drpi_pkg::dp_status_t   status,
    output drpi_pkg::drpi_out_t    pose
);
    import drpi_pkg::*;

    localparam int STEPS  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int ITER_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(STEPS - 1);

    localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 34'sd2147483648;

    // Round half up from Q4.30 to Q1.15 with clamping.
    function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (r < -34'sd32768)
        begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    // Add a 34-bit signed delta to a 32-bit position with saturation.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [33:0] d);
        logic signed [34:0] s;
        s = {{3{p[31]}}, p} + {d[33], d};
        if (s > 35'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (s < -35'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    drpi_in_t                    in_reg;
    drpi_out_t                   out_reg;
    logic signed [31:0]          pos_x_reg, pos_x_next;
    logic signed [31:0]          pos_y_reg, pos_y_next;
    logic        [31:0]          heading_reg, heading_next;

    logic signed [CORDIC_W-1:0]  x_reg, y_reg, a_reg;
    logic                        flip_reg;
    logic        [ITER_W-1:0]    iter_reg;
    logic signed [TRIG_W-1:0]    cq_reg, sq_reg;
    logic signed [MUL_P_W-1:0]   mul_reg;
    logic signed [PROD_W-1:0]    dist_reg, wd_reg;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;

    logic        [31:0]          ang;
    logic signed [CORDIC_W-1:0]  a_raw, a_red;
    logic                        flip_red;
    logic signed [CORDIC_W-1:0]  x_sh, y_sh, atan_v;
    logic signed [CORDIC_W-1:0]  c_res, s_res, c_rnd, s_rnd;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]     prod_ext;

    // Angle reduction into the convergence range of the rotator.
    always_comb
    begin
        ang      = cmd.rot_half ? {1'b0, heading_reg[31:1]} : heading_reg;
        a_raw    = $signed({{2{ang[31]}}, ang});
        a_red    = a_raw;
        flip_red = 1'b0;
        if (a_raw > QUARTER_TURN)
        begin
            a_red    = a_raw - HALF_TURN;
            flip_red = 1'b1;
        end
        else if (a_raw < -QUARTER_TURN)
        begin
            a_red    = a_raw + HALF_TURN;
            flip_red = 1'b1;
        end
    end

    always_comb
    begin
        x_sh   = x_reg >>> iter_reg;
        y_sh   = y_reg >>> iter_reg;
        atan_v = $signed({4'b0, atan_turn(5'(iter_reg))});
        c_res  = flip_reg ? -x_reg : x_reg;
        s_res  = flip_reg ? -y_reg : y_reg;
        c_rnd  = (c_res + 34'sd128) >>> 8;
        s_rnd  = (s_res + 34'sd128) >>> 8;
    end

    assign status.rot_last = (iter_reg == ITER_LAST);

    always_ff @(posedge clk)
    begin
        if (cmd.rot_load)
        begin
            x_reg    <= $signed({4'b0, TRIG_GAIN_Q30});
            y_reg    <= '0;
            a_reg    <= a_red;
            flip_reg <= flip_red;
            iter_reg <= '0;
        end
        else if (cmd.rot_step)
        begin
            if (!a_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                a_reg <= a_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                a_reg <= a_reg + atan_v;
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.trig_load)
        begin
            cq_reg <= c_rnd[TRIG_W-1:0];
            sq_reg <= s_rnd[TRIG_W-1:0];
        end
        if (cmd.in_load)
        begin
            in_reg <= tick;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.slot.mul_op)
            MUL_V_DT:
            begin
                mul_a = {in_reg.linear_speed[23], in_reg.linear_speed};
                mul_b = {16'b0, in_reg.time_step};
            end
            MUL_W_DT:
            begin
                mul_a = {in_reg.yaw_rate[23], in_reg.yaw_rate};
                mul_b = {16'b0, in_reg.time_step};
            end
            MUL_DHI_CQ:
            begin
                mul_a = {dist_reg[PROD_W-1], dist_reg[PROD_W-1:16]};
                mul_b = {{(MUL_B_W-TRIG_W){cq_reg[TRIG_W-1]}}, cq_reg};
            end
            MUL_DLO_CQ:
            begin
                mul_a = {9'b0, dist_reg[15:0]};
                mul_b = {{(MUL_B_W-TRIG_W){cq_reg[TRIG_W-1]}}, cq_reg};
            end
            MUL_DHI_SQ:
            begin
                mul_a = {dist_reg[PROD_W-1], dist_reg[PROD_W-1:16]};
                mul_b = {{(MUL_B_W-TRIG_W){sq_reg[TRIG_W-1]}}, sq_reg};
            end
            MUL_DLO_SQ:
            begin
                mul_a = {9'b0, dist_reg[15:0]};
                mul_b = {{(MUL_B_W-TRIG_W){sq_reg[TRIG_W-1]}}, sq_reg};
            end
            MUL_WHI_K:
            begin
                mul_a = {wd_reg[PROD_W-1], wd_reg[PROD_W-1:16]};
                mul_b = {2'b0, INV_TWO_PI_Q32};
            end
            MUL_WLO_K:
            begin
                mul_a = {9'b0, wd_reg[15:0]};
                mul_b = {2'b0, INV_TWO_PI_Q32};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Act on the product registered in the previous slot.
    always_comb
    begin
        prod_ext     = $signed({{(ACC_W-MUL_P_W){mul_reg[MUL_P_W-1]}}, mul_reg});
        acc_next     = acc_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        case (cmd.slot.act)
            ACT_ACC_HI_POS:  acc_next = (prod_ext <<< 16) + (72'sd1 <<< 37);
            ACT_ACC_HI_HEAD: acc_next = (prod_ext <<< 16) + (72'sd1 <<< 31);
            ACT_ACC_LO:      acc_next = acc_reg + prod_ext;
            ACT_WRITE_X:     pos_x_next = sat_add(pos_x_reg, acc_reg[ACC_W-1:38]);
            ACT_WRITE_Y:     pos_y_next = sat_add(pos_y_reg, acc_reg[ACC_W-1:38]);
            ACT_WRITE_H:     heading_next = heading_reg + acc_reg[63:32];
            default:         acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        acc_reg <= acc_next;
        if (cmd.slot.act == ACT_STORE_DIST)
        begin
            dist_reg <= mul_reg[PROD_W-1:0];
        end
        if (cmd.slot.act == ACT_STORE_WD)
        begin
            wd_reg <= mul_reg[PROD_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_reg.pos_x_out     <= pos_x_reg;
            out_reg.pos_y_out     <= pos_y_reg;
            out_reg.heading_out   <= heading_reg;
            out_reg.quat_z        <= to_q15(s_res);
            out_reg.quat_w        <= to_q15(c_res);
            out_reg.speed_echo    <= in_reg.linear_speed;
            out_reg.lateral_echo  <= in_reg.lateral_speed;
            out_reg.yaw_rate_echo <= in_reg.yaw_rate;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end
        else
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
        end
    end

    assign pose = out_reg;

endmodule

// ----- sv/dead_reckoning_pose_integrator.sv -----
// A tick accepted in idle passes through the first rotation, the trig load, the multiply slots,
// the second rotation and the final state before its pose is loaded. A new tick is taken only in
// idle: two passes of the one CORDIC rotator and twelve slots of the shared multiplier set the rate.
// The pose output register frees the input side, so the next tick is taken while a pose waits.
// Reset (rst_n, asynchronous, active low) clears position and heading to zero and empties the output.
module dead_reckoning_pose_integrator #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_stall,
    input  drpi_pkg::drpi_in_t  tick,
    output logic                pose_valid,
    input  logic                pose_stall,
    output drpi_pkg::drpi_out_t pose
);
    import drpi_pkg::*;

    // The controller owns all sequencing and both handshakes; the datapath owns every
    // arithmetic register and the persistent pose (x, y, heading).
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Per tick the controller runs: a CORDIC pass over the old heading, rounding of
    // cos/sin to Q.22, a fixed multiply schedule that forms the distance, both position
    // deltas and the heading increment, then a CORDIC pass over half the new heading
    // for the quaternion, and finally a load of the output register.
    drpi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .pose_valid (pose_valid),
        .pose_stall (pose_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds one rotator that iterates one CORDIC step per cycle and a
    // single 25x32 multiplier whose product is registered before it is accumulated.
    drpi_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .cmd    (cmd),
        .status (status),
        .pose   (pose)
    );

endmodule
